// ===== src/sst_pkg.sv =====
// Package for the script source tokenizer: scan modes, token kind codes,
// status codes, result record type and character class helpers. No dependencies.
package sst_pkg;

	localparam int POS_BITS_DEF  = 16;
	localparam int LINE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = 2;

	typedef enum logic [3:0] {
		M_IDLE      = 4'd0,
		M_OP        = 4'd1,
		M_SLASH     = 4'd2,
		M_LINECOM   = 4'd3,
		M_BLOCK     = 4'd4,
		M_BLOCKSTAR = 4'd5,
		M_STRING    = 4'd6,
		M_INT       = 4'd7,
		M_INTDOT    = 4'd8,
		M_FRAC      = 4'd9,
		M_WORD      = 4'd10
	} mode_t;

	localparam logic [5:0] K_DOT    = 6'd5;
	localparam logic [5:0] K_BANG   = 6'd10;
	localparam logic [5:0] K_EQUAL  = 6'd12;
	localparam logic [5:0] K_LESS   = 6'd14;
	localparam logic [5:0] K_GREATER = 6'd16;
	localparam logic [5:0] K_SLASH  = 6'd18;
	localparam logic [5:0] K_STRING = 6'd19;
	localparam logic [5:0] K_NUMBER = 6'd20;
	localparam logic [5:0] K_IDENT  = 6'd21;
	localparam logic [5:0] K_KW0    = 6'd22;
	localparam logic [5:0] K_NONE   = 6'd0;

	localparam logic [1:0] ST_TOKEN  = 2'd0;
	localparam logic [1:0] ST_UNEXP  = 2'd1;
	localparam logic [1:0] ST_UNTERM = 2'd2;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start_pos;
		logic [15:0] length;
		logic [15:0] start_line;
		logic [15:0] end_line;
		logic [1:0]  status;
		logic        last;
	} token_t;

	typedef logic [47:0] kw_buf_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h5f;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] ch, input logic two);
		logic [5:0] b;
		case (ch)
			8'h21:   b = K_BANG;
			8'h3d:   b = K_EQUAL;
			8'h3c:   b = K_LESS;
			default: b = K_GREATER;
		endcase
		return b + {5'd0, two};
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] c, output logic hit);
		logic [5:0] k;
		hit = 1'b1;
		case (c)
			8'h28:   k = 6'd0;
			8'h29:   k = 6'd1;
			8'h7b:   k = 6'd2;
			8'h7d:   k = 6'd3;
			8'h2c:   k = 6'd4;
			8'h2e:   k = 6'd5;
			8'h2d:   k = 6'd6;
			8'h2b:   k = 6'd7;
			8'h3b:   k = 6'd8;
			8'h2a:   k = 6'd9;
			default: begin
				k = 6'd0;
				hit = 1'b0;
			end
		endcase
		return k;
	endfunction

	function automatic logic [5:0] word_kind(input kw_buf_t b, input logic [2:0] n);
		logic [5:0] k;
		k = K_IDENT;
		case (n)
			3'd2: begin
				if (b[15:0] == 16'h6669) k = K_KW0 + 6'd6;
				if (b[15:0] == 16'h726f) k = K_KW0 + 6'd8;
			end
			3'd3: begin
				if (b[23:0] == 24'h646e61) k = K_KW0 + 6'd0;
				if (b[23:0] == 24'h6e7566) k = K_KW0 + 6'd4;
				if (b[23:0] == 24'h726f66) k = K_KW0 + 6'd5;
				if (b[23:0] == 24'h6c696e) k = K_KW0 + 6'd7;
				if (b[23:0] == 24'h726176) k = K_KW0 + 6'd14;
			end
			3'd4: begin
				if (b[31:0] == 32'h65736c65) k = K_KW0 + 6'd2;
				if (b[31:0] == 32'h73696874) k = K_KW0 + 6'd12;
				if (b[31:0] == 32'h65757274) k = K_KW0 + 6'd13;
			end
			3'd5: begin
				if (b[39:0] == 40'h7373616c63) k = K_KW0 + 6'd1;
				if (b[39:0] == 40'h65736c6166) k = K_KW0 + 6'd3;
				if (b[39:0] == 40'h746e697270) k = K_KW0 + 6'd9;
				if (b[39:0] == 40'h7265707573) k = K_KW0 + 6'd11;
				if (b[39:0] == 40'h656c696877) k = K_KW0 + 6'd15;
			end
			3'd6: begin
				if (b[47:0] == 48'h6e7275746572) k = K_KW0 + 6'd10;
			end
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage

// ===== src/sst_if.sv =====
// Valid/ready stream interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
interface sst_if #(parameter type payload_t = logic [8:0]) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/sst_front.sv =====
// Front part: accepts bytes, runs the scan mode machine and builds up to three
// result records per byte. Depends on sst_pkg.
module sst_front #(
	parameter int POS_BITS  = sst_pkg::POS_BITS_DEF,
	parameter int LINE_BITS = sst_pkg::LINE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     in_byte,
	input  logic           in_eos,
	output logic           in_ready,
	input  logic           room,
	output logic           push,
	output logic [1:0]     push_n,
	output sst_pkg::token_t res [3]
);
	localparam logic [POS_BITS-1:0]  PMAX = '1;
	localparam logic [LINE_BITS-1:0] LMAX = '1;

	sst_pkg::mode_t       mode_q, mode_d;
	logic [7:0]           pend_q, pend_d;
	logic [POS_BITS-1:0]  pos_q, pos_d, lstart_q, lstart_d;
	logic [LINE_BITS-1:0] line_q, line_d, lline_q, lline_d;
	sst_pkg::kw_buf_t     kbuf_q, kbuf_d;
	logic [2:0]           wlen_q, wlen_d;
	logic                 err_q, err_d;
	logic                 fire;
	logic [1:0]           n;

	assign in_ready = room;
	assign fire = in_valid && room;
	assign push = fire && !err_q && n != 2'd0;
	assign push_n = n;

	function automatic logic [15:0] sat_p(input logic [POS_BITS-1:0] v);
		if (POS_BITS > 16 && (v >> 16) != '0) return 16'hffff;
		return 16'(v);
	endfunction

	function automatic logic [15:0] sat_w(input logic [POS_BITS:0] v);
		if ((v >> 16) != '0) return 16'hffff;
		return 16'(v);
	endfunction

	function automatic logic [15:0] sat_l(input logic [LINE_BITS-1:0] v);
		if (LINE_BITS > 16 && (v >> 16) != '0) return 16'hffff;
		return 16'(v);
	endfunction

	always_comb begin
		logic [POS_BITS-1:0] pos, npos, dotp;
		logic [POS_BITS:0]   endp;
		logic                again, hit;
		logic [5:0]          pk;
		sst_pkg::token_t     t;
		mode_d = mode_q;
		pend_d = pend_q;
		pos_d = pos_q;
		lstart_d = lstart_q;
		line_d = line_q;
		lline_d = lline_q;
		kbuf_d = kbuf_q;
		wlen_d = wlen_q;
		err_d = err_q;
		n = 2'd0;
		res[0] = '0;
		res[1] = '0;
		res[2] = '0;
		pos = pos_q;
		npos = (pos_q != PMAX) ? pos_q + 1'b1 : PMAX;
		again = 1'b0;
		hit = 1'b0;
		pk = '0;
		t = '0;
		endp = '0;
		dotp = '0;
		if (fire && !err_q) begin
			for (int pass = 0; pass < 2; pass++) begin
				if (pass == 0 || (again && !err_d)) begin
					again = 1'b0;
					t = '0;
					endp = {1'b0, pos};
					case (mode_d)
						sst_pkg::M_OP: begin
							mode_d = sst_pkg::M_IDLE;
							if (in_byte == 8'h3d) begin
								t.kind = sst_pkg::op_kind(pend_d, 1'b1);
								endp = {1'b0, pos} + 1'b1;
							end else begin
								t.kind = sst_pkg::op_kind(pend_d, 1'b0);
								again = 1'b1;
							end
							t.status = 2'd3;
						end
						sst_pkg::M_SLASH: begin
							if (in_byte == 8'h2a) mode_d = sst_pkg::M_BLOCK;
							else if (in_byte == 8'h2f) mode_d = sst_pkg::M_LINECOM;
							else begin
								mode_d = sst_pkg::M_IDLE;
								t.kind = sst_pkg::K_SLASH;
								t.status = 2'd3;
								again = 1'b1;
							end
						end
						sst_pkg::M_LINECOM: begin
							if (in_byte == 8'h0a) begin
								mode_d = sst_pkg::M_IDLE;
								again = 1'b1;
							end
						end
						sst_pkg::M_BLOCK, sst_pkg::M_BLOCKSTAR: begin
							if (mode_d == sst_pkg::M_BLOCKSTAR && in_byte == 8'h2f)
								mode_d = sst_pkg::M_IDLE;
							else begin
								mode_d = (in_byte == 8'h2a) ? sst_pkg::M_BLOCKSTAR
								                            : sst_pkg::M_BLOCK;
								if (in_byte == 8'h0a && line_d != LMAX) line_d = line_d + 1'b1;
							end
						end
						sst_pkg::M_STRING: begin
							if (in_byte == 8'h22) begin
								mode_d = sst_pkg::M_IDLE;
								t.kind = sst_pkg::K_STRING;
								t.status = 2'd3;
								endp = {1'b0, pos} + 1'b1;
							end else if (in_byte == 8'h0a && line_d != LMAX)
								line_d = line_d + 1'b1;
						end
						sst_pkg::M_INT, sst_pkg::M_FRAC: begin
							if (sst_pkg::is_digit(in_byte)) begin
							end else if (in_byte == 8'h2e && mode_d == sst_pkg::M_INT)
								mode_d = sst_pkg::M_INTDOT;
							else begin
								mode_d = sst_pkg::M_IDLE;
								t.kind = sst_pkg::K_NUMBER;
								t.status = 2'd3;
								again = 1'b1;
							end
						end
						sst_pkg::M_INTDOT: begin
							if (sst_pkg::is_digit(in_byte)) mode_d = sst_pkg::M_FRAC;
							else begin
								mode_d = sst_pkg::M_IDLE;
								again = 1'b1;
								dotp = (pos > lstart_d) ? pos - 1'b1 : pos;
								res[n] = '{sst_pkg::K_NUMBER, sat_p(lstart_d),
									sat_p((dotp >= lstart_d) ? dotp - lstart_d : '0),
									sat_l(lline_d), sat_l(line_d), sst_pkg::ST_TOKEN, 1'b0};
								n = n + 2'd1;
								lstart_d = dotp;
								lline_d = line_d;
								t.kind = sst_pkg::K_DOT;
								t.status = 2'd3;
							end
						end
						sst_pkg::M_WORD: begin
							if (sst_pkg::is_word(in_byte)) begin
								if (wlen_d < 3'd6) begin
									kbuf_d[8*wlen_d +: 8] = in_byte;
									wlen_d = wlen_d + 3'd1;
								end else wlen_d = 3'd7;
							end else begin
								mode_d = sst_pkg::M_IDLE;
								t.kind = sst_pkg::word_kind(kbuf_d, wlen_d);
								t.status = 2'd3;
								again = 1'b1;
							end
						end
						default: begin
							mode_d = sst_pkg::M_IDLE;
							lstart_d = pos;
							lline_d = line_d;
							pk = sst_pkg::punct_kind(in_byte, hit);
							endp = {1'b0, pos} + 1'b1;
							if (hit) begin
								t.kind = pk;
								t.status = 2'd3;
							end else if (in_byte == 8'h21 || in_byte == 8'h3d ||
							             in_byte == 8'h3c || in_byte == 8'h3e) begin
								mode_d = sst_pkg::M_OP;
								pend_d = in_byte;
							end else if (in_byte == 8'h2f) mode_d = sst_pkg::M_SLASH;
							else if (in_byte == 8'h22) mode_d = sst_pkg::M_STRING;
							else if (sst_pkg::is_digit(in_byte)) mode_d = sst_pkg::M_INT;
							else if (sst_pkg::is_alpha(in_byte) || in_byte == 8'h5f) begin
								mode_d = sst_pkg::M_WORD;
								kbuf_d = {40'd0, in_byte};
								wlen_d = 3'd1;
							end else if (in_byte == 8'h0a) begin
								if (line_d != LMAX) line_d = line_d + 1'b1;
							end else if (in_byte == 8'h20 || in_byte == 8'h09 ||
							             in_byte == 8'h0b || in_byte == 8'h0c ||
							             in_byte == 8'h0d) begin
							end else begin
								t.kind = sst_pkg::K_NONE;
								t.status = 2'd1;
								err_d = 1'b1;
							end
						end
					endcase
					if (t.status != 2'd0) begin
						res[n] = '{t.kind, sat_p(lstart_d),
							sat_w((endp >= {1'b0, lstart_d}) ? endp - {1'b0, lstart_d} : '0),
							sat_l(lline_d), sat_l(line_d),
							(t.status == 2'd3) ? sst_pkg::ST_TOKEN : t.status, 1'b0};
						n = n + 2'd1;
					end
				end
			end
			if (in_eos) begin
				if (!err_d) begin
					t = '0;
					case (mode_d)
						sst_pkg::M_OP: t.kind = sst_pkg::op_kind(pend_d, 1'b0);
						sst_pkg::M_SLASH: t.kind = sst_pkg::K_SLASH;
						sst_pkg::M_STRING: begin
							t.kind = sst_pkg::K_NONE;
							err_d = 1'b1;
						end
						sst_pkg::M_INT, sst_pkg::M_FRAC: t.kind = sst_pkg::K_NUMBER;
						sst_pkg::M_INTDOT: begin
							dotp = (npos > lstart_d) ? npos - 1'b1 : npos;
							res[n] = '{sst_pkg::K_NUMBER, sat_p(lstart_d),
								sat_p((dotp >= lstart_d) ? dotp - lstart_d : '0),
								sat_l(lline_d), sat_l(line_d), sst_pkg::ST_TOKEN, 1'b0};
							n = n + 2'd1;
							lstart_d = dotp;
							lline_d = line_d;
							t.kind = sst_pkg::K_DOT;
						end
						sst_pkg::M_WORD: t.kind = sst_pkg::word_kind(kbuf_d, wlen_d);
						default: t.kind = sst_pkg::K_NONE;
					endcase
					if (mode_d == sst_pkg::M_OP || mode_d == sst_pkg::M_SLASH ||
					    mode_d == sst_pkg::M_STRING || mode_d == sst_pkg::M_INT ||
					    mode_d == sst_pkg::M_FRAC || mode_d == sst_pkg::M_INTDOT ||
					    mode_d == sst_pkg::M_WORD) begin
						res[n] = '{t.kind, sat_p(lstart_d),
							sat_p((npos >= lstart_d) ? npos - lstart_d : '0),
							sat_l(lline_d), sat_l(line_d),
							(mode_d == sst_pkg::M_STRING) ? sst_pkg::ST_UNTERM
							                              : sst_pkg::ST_TOKEN, 1'b0};
						n = n + 2'd1;
					end
				end
				mode_d = sst_pkg::M_IDLE;
				pend_d = '0;
				pos_d = '0;
				lstart_d = '0;
				line_d = LINE_BITS'(1);
				lline_d = LINE_BITS'(1);
				kbuf_d = '0;
				wlen_d = '0;
			end else pos_d = npos;
			if (n != 2'd0) res[n - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sst_pkg::M_IDLE;
			pend_q <= '0;
			pos_q <= '0;
			lstart_q <= '0;
			line_q <= LINE_BITS'(1);
			lline_q <= LINE_BITS'(1);
			kbuf_q <= '0;
			wlen_q <= '0;
			err_q <= 1'b0;
		end else if (fire && !err_q) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			pos_q <= pos_d;
			lstart_q <= lstart_d;
			line_q <= line_d;
			lline_q <= lline_d;
			kbuf_q <= kbuf_d;
			wlen_q <= wlen_d;
			err_q <= err_d;
		end
	end
endmodule

// ===== src/sst_back.sv =====
// Back part: a short queue of result records, written up to three at a time,
// drained one per cycle to the output channel while it is ready. Depends on sst_pkg.
module sst_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [1:0]      push_n,
	input  sst_pkg::token_t res [3],
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output sst_pkg::token_t out_data
);
	localparam int D = sst_pkg::QUEUE_DEPTH;
	localparam int AW = sst_pkg::QUEUE_AW;

	sst_pkg::token_t  mem_q [D];
	logic [AW-1:0]    rd_q, wr_q;
	logic [AW:0]      cnt_q;
	logic             pop;

	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	assign room = cnt_q <= (AW+1)'(D - 3) || (pop && cnt_q == (AW+1)'(D - 2));

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < 3; i++)
				if (2'(i) < push_n) mem_q[wr_q + AW'(i)] <= res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(push_n);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? (AW+1)'(push_n) : '0) - (pop ? (AW+1)'(1) : '0);
		end
	end
endmodule

// ===== src/script_source_tokenizer.sv =====
// Streaming tokenizer top level: front scanner feeding a four-entry result queue.
// Results of an accepted byte are registered into the queue and reach the output in order.
// Throughput: one byte per cycle while the queue has room for three results;
// drain is one result per cycle through the queue's read port while out_ch is ready.
// Reset clears mode, position counters, error flag and queue pointers at once and sets the line counters to one.
module script_source_tokenizer #(
	parameter int POS_BITS  = sst_pkg::POS_BITS_DEF,
	parameter int LINE_BITS = sst_pkg::LINE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	sst_if.sink   in_ch,
	sst_if.source out_ch
);
	logic            room, push;
	logic [1:0]      push_n;
	sst_pkg::token_t res [3];
	sst_pkg::token_t od;

	sst_front #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_byte(in_ch.data[7:0]), .in_eos(in_ch.data[8]),
		.in_ready(in_ch.ready), .room, .push, .push_n, .res
	);

	sst_back u_back (
		.clk, .arst_n, .push, .push_n, .res, .room,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(od)
	);

	assign out_ch.data = od;

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("push without room");
	a_ready_is_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == room)
		else $error("ready mismatch");
	a_err_status_zero_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && od.status != sst_pkg::ST_TOKEN |-> od.kind == sst_pkg::K_NONE)
		else $error("error result with kind");
`endif
endmodule
